// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define BSP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define BSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/bsp_pkg.sv -----
// shared types and constants of the blink sequence pwm timer
`timescale 1ns / 1ps

package bsp_pkg;

  localparam int TICKS_PER_STEP = 100;
  localparam int MS_W = $clog2(TICKS_PER_STEP + 1);

  localparam int FIELD_W = 7;
  localparam int CMP_W = 16;

  localparam logic [CMP_W-1:0] DARK_VALUE = 16'hFFFF;
  localparam logic [CMP_W-1:0] FULL_ON_VALUE = 16'h0000;
  localparam logic [FIELD_W-1:0] PCT_MAX = 7'd100;
  localparam logic [FIELD_W-1:0] TIME_MAX = 7'd99;

  // floor(x / 100) as (x * SCALE_RECIP) >> SCALE_SHIFT for x below 65535 * 100
  localparam int SCALE_SHIFT = 30;
  localparam logic [23:0] SCALE_RECIP = 24'd10737419;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_START    = 3'd1,
    OP_STOP     = 3'd2,
    OP_FULL_ON  = 3'd3,
    OP_FULL_OFF = 3'd4
  } op_e;

  typedef struct packed {
    logic [2:0]         op;
    logic [FIELD_W-1:0] intensity;
    logic [FIELD_W-1:0] on_time;
    logic [FIELD_W-1:0] off_time;
    logic [FIELD_W-1:0] flash_count;
  } word_t;

  typedef struct packed {
    logic [CMP_W-1:0] compare_value;
    logic             running;
    logic             lit_phase;
    logic             error;
  } res_t;

endpackage

// ----- rtl/bsp_scale.sv -----
// percent to pwm compare value, floor(65535 * (100 - p) / 100)
`timescale 1ns / 1ps

module bsp_scale (
  input  logic [bsp_pkg::FIELD_W-1:0] pct_i,
  output logic [bsp_pkg::CMP_W-1:0]   compare_o
);

  localparam int X_W = bsp_pkg::FIELD_W + bsp_pkg::CMP_W;
  localparam int P_W = X_W + 24;

  logic [bsp_pkg::FIELD_W-1:0] dark_pct;
  logic [X_W-1:0]              scaled;
  logic [P_W-1:0]              prod;

  // percent above 100 clamps to fully lit
  assign dark_pct = (pct_i > bsp_pkg::PCT_MAX) ? '0 : (bsp_pkg::PCT_MAX - pct_i);
  // 65535 * q as (q << 16) - q
  assign scaled = {dark_pct, {bsp_pkg::CMP_W{1'b0}}} - X_W'(dark_pct);
  assign prod = P_W'(scaled) * P_W'(bsp_pkg::SCALE_RECIP);
  assign compare_o = prod[bsp_pkg::SCALE_SHIFT +: bsp_pkg::CMP_W];

endmodule

// ----- rtl/bsp_step.sv -----
// sequence state and its update for one accepted word
`timescale 1ns / 1ps

module bsp_step (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  bsp_pkg::word_t  word_i,
  output bsp_pkg::res_t   res_o
);

  localparam logic [bsp_pkg::MS_W:0] TICKS_C = (bsp_pkg::MS_W + 1)'(bsp_pkg::TICKS_PER_STEP);

  logic [bsp_pkg::MS_W-1:0]    ms_count_q, ms_count_d;
  logic [bsp_pkg::FIELD_W-1:0] step_count_q, step_count_d;
  logic                        in_on_q, in_on_d;
  logic                        active_q, active_d;
  logic [bsp_pkg::FIELD_W-1:0] flashes_q, flashes_d;
  logic [bsp_pkg::FIELD_W-1:0] held_int_q, held_int_d;
  logic [bsp_pkg::FIELD_W-1:0] held_on_q, held_on_d;
  logic [bsp_pkg::FIELD_W-1:0] held_off_q, held_off_d;
  logic [bsp_pkg::CMP_W-1:0]   compare_q, compare_d;

  logic [bsp_pkg::MS_W:0]      ms_inc;
  logic [bsp_pkg::FIELD_W-1:0] scale_pct;
  logic [bsp_pkg::CMP_W-1:0]   scale_val;
  logic                        bad_start;
  logic                        err;

  // one shared scaler: the start operand or the held intensity on relight
  assign scale_pct = (word_i.op == bsp_pkg::OP_START) ? word_i.intensity : held_int_q;

  bsp_scale u_scale (
    .pct_i     (scale_pct),
    .compare_o (scale_val)
  );

  assign bad_start = (word_i.intensity < 7'd1) || (word_i.intensity > bsp_pkg::PCT_MAX) ||
                     (word_i.on_time < 7'd1) || (word_i.on_time > bsp_pkg::TIME_MAX) ||
                     (word_i.off_time > bsp_pkg::TIME_MAX) ||
                     (word_i.flash_count < 7'd1) || (word_i.flash_count > bsp_pkg::TIME_MAX);

  assign ms_inc = {1'b0, ms_count_q} + 1'b1;

  always_comb begin
    ms_count_d   = ms_count_q;
    step_count_d = step_count_q;
    in_on_d      = in_on_q;
    active_d     = active_q;
    flashes_d    = flashes_q;
    held_int_d   = held_int_q;
    held_on_d    = held_on_q;
    held_off_d   = held_off_q;
    compare_d    = compare_q;
    err          = 1'b0;
    case (word_i.op)
      bsp_pkg::OP_TICK: begin
        if (active_q) begin
          if (ms_inc < TICKS_C) begin
            ms_count_d = ms_inc[bsp_pkg::MS_W-1:0];
          end else begin
            ms_count_d   = '0;
            step_count_d = step_count_q + 1'b1;
            if (in_on_q && (step_count_d >= held_on_q)) begin
              in_on_d      = 1'b0;
              step_count_d = '0;
              compare_d    = bsp_pkg::DARK_VALUE;
            end
            // zero off time falls straight through to the relight
            if (!in_on_d && (step_count_d >= held_off_q)) begin
              flashes_d = flashes_q - 1'b1;
              if (flashes_d == '0) begin
                active_d  = 1'b0;
                compare_d = bsp_pkg::DARK_VALUE;
              end else begin
                in_on_d      = 1'b1;
                step_count_d = '0;
                compare_d    = scale_val;
              end
            end
          end
        end
      end
      bsp_pkg::OP_START: begin
        if (bad_start) begin
          err = 1'b1;
        end else begin
          held_int_d   = word_i.intensity;
          held_on_d    = word_i.on_time;
          held_off_d   = word_i.off_time;
          flashes_d    = word_i.flash_count;
          active_d     = 1'b1;
          step_count_d = '0;
          in_on_d      = 1'b1;
          compare_d    = scale_val;
        end
      end
      bsp_pkg::OP_STOP: begin
        active_d  = 1'b0;
        compare_d = bsp_pkg::DARK_VALUE;
      end
      bsp_pkg::OP_FULL_ON: begin
        compare_d = bsp_pkg::FULL_ON_VALUE;
      end
      bsp_pkg::OP_FULL_OFF: begin
        compare_d = bsp_pkg::DARK_VALUE;
      end
      default: begin
      end
    endcase
  end

  assign res_o.compare_value = compare_d;
  assign res_o.running       = active_d;
  assign res_o.lit_phase     = active_d && in_on_d;
  assign res_o.error         = err;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_count_q   <= '0;
      step_count_q <= '0;
      in_on_q      <= 1'b0;
      active_q     <= 1'b0;
      flashes_q    <= '0;
      held_int_q   <= '0;
      held_on_q    <= '0;
      held_off_q   <= '0;
      compare_q    <= bsp_pkg::DARK_VALUE;
    end else if (fire_i) begin
      ms_count_q   <= ms_count_d;
      step_count_q <= step_count_d;
      in_on_q      <= in_on_d;
      active_q     <= active_d;
      flashes_q    <= flashes_d;
      held_int_q   <= held_int_d;
      held_on_q    <= held_on_d;
      held_off_q   <= held_off_d;
      compare_q    <= compare_d;
    end
  end

endmodule

// ----- rtl/blink_sequence_pwm_timer_core.sv -----
// Flash sequence pwm timer. Takes one word per cycle (tick, start, stop, full on,
// full off) unless in_stall_o is raised, and returns one result word for each, in
// order. A word is first held in the input register, then the sequence state is
// updated and the result is captured in the output register, which holds it while
// out_stall_i is high. The input register and the output register together hold
// two words, which keeps one word per cycle moving while the far side takes
// results without stalling.
`timescale 1ns / 1ps

module blink_sequence_pwm_timer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  op_i,
  input  logic [bsp_pkg::FIELD_W-1:0] intensity_i,
  input  logic [bsp_pkg::FIELD_W-1:0] on_time_i,
  input  logic [bsp_pkg::FIELD_W-1:0] off_time_i,
  input  logic [bsp_pkg::FIELD_W-1:0] flash_count_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [bsp_pkg::CMP_W-1:0]   compare_value_o,
  output logic                        running_o,
  output logic                        lit_phase_o,
  output logic                        error_o
);

  logic           in_vld_q;
  bsp_pkg::word_t in_word_q;
  logic           out_vld_q;
  bsp_pkg::res_t  out_res_q;
  bsp_pkg::res_t  step_res;
  logic           out_free;
  logic           fire;

  assign out_free   = !out_vld_q || !out_stall_i;
  assign fire       = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q.op          <= op_i;
      in_word_q.intensity   <= intensity_i;
      in_word_q.on_time     <= on_time_i;
      in_word_q.off_time    <= off_time_i;
      in_word_q.flash_count <= flash_count_i;
    end
  end

  bsp_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .word_i (in_word_q),
    .res_o  (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign compare_value_o = out_res_q.compare_value;
  assign running_o       = out_res_q.running;
  assign lit_phase_o     = out_res_q.lit_phase;
  assign error_o         = out_res_q.error;

endmodule

// ----- rtl/bsp_checker.sv -----
// port-level checks of the blink sequence pwm timer, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [bsp_pkg::CMP_W-1:0]   compare_value_o,
  input logic                        running_o,
  input logic                        lit_phase_o,
  input logic                        error_o
);

  // a stalled result word holds
  `BSP_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(compare_value_o) && $stable(running_o) && $stable(lit_phase_o) && $stable(error_o), "stalled result word changed")

  // lit phase is only reported while a sequence runs
  `BSP_ASSERT_IMPL(a_lit_running, clk_i, rst_ni, out_valid_o && lit_phase_o, running_o, "lit phase without running")

  // a result word appearing on an empty output came from an accepted input word, via the input register
  `BSP_ASSERT_IMPL(a_out_origin, clk_i, rst_ni, $rose(out_valid_o), $past(in_valid_i && !in_stall_o, 2), "result word without accepted input word")

  // an error word that reports no running sequence reports no lit phase either
  `BSP_ASSERT_IMPL(a_err_state, clk_i, rst_ni, out_valid_o && error_o && !running_o, !lit_phase_o, "error word reports lit phase while idle")

endmodule

bind blink_sequence_pwm_timer_core bsp_checker u_bsp_checker (.*);
